// ===== rtl/sec_pkg.sv =====
// Shared types and constants of the squared exponential covariance block.
// No dependencies; every other file but sec_if imports this package.
package sec_pkg;

    localparam int NLANE    = 4;
    localparam int COORD_W  = 16;
    localparam int LEN_W    = 16;
    localparam int VAL_W    = 32;
    localparam int MQ_W     = 23;
    localparam int NEXP_W   = 7;
    localparam int ORDER    = 12;
    localparam int RECIP_SH = 36;
    localparam int RECIP_W  = 37;

    // log2(e)/2 and ln(2), both in Q0.32.
    localparam logic [31:0] HALF_LOG2E = 32'hB8AA3B29;
    localparam logic [31:0] LN2        = 32'hB17217F8;
    localparam logic [32:0] ONE_Q32    = 33'h1_0000_0000;

    typedef enum logic [2:0] {
        REG_AMP  = 3'd0,
        REG_NUG  = 3'd1,
        REG_LEN0 = 3'd2,
        REG_LEN1 = 3'd3,
        REG_LEN2 = 3'd4,
        REG_LEN3 = 3'd5
    } cfg_reg_t;

    // Distance summary handed from the front part to the exponent part.
    typedef struct packed {
        logic [MQ_W-1:0] mq;
        logic            coin;
        logic            near;
    } dist_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    // Side information that travels with an item through the series.
    typedef struct packed {
        logic [NEXP_W-1:0] n;
        logic              coin;
        logic              near;
    } side_t;

    // floor(2^36 / k) for the divisors of the series.
    function automatic logic [RECIP_W-1:0] recip(input logic [3:0] k);
        logic [RECIP_W-1:0] r;
        case (k)
            4'd1:    r = 37'd68719476736;
            4'd2:    r = 37'd34359738368;
            4'd3:    r = 37'd22906492245;
            4'd4:    r = 37'd17179869184;
            4'd5:    r = 37'd13743895347;
            4'd6:    r = 37'd11453246122;
            4'd7:    r = 37'd9817068105;
            4'd8:    r = 37'd8589934592;
            4'd9:    r = 37'd7635497415;
            4'd10:   r = 37'd6871947673;
            4'd11:   r = 37'd6247225157;
            4'd12:   r = 37'd5726623061;
            default: r = 37'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/sec_if.sv =====
// Request and result channel interfaces of the covariance block.
// Depends on nothing; the payload widths are those of the block's fields.
interface sec_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] xa_0;
    logic signed [15:0] xa_1;
    logic signed [15:0] xa_2;
    logic signed [15:0] xa_3;
    logic signed [15:0] yb_0;
    logic signed [15:0] yb_1;
    logic signed [15:0] yb_2;
    logic signed [15:0] yb_3;

    modport source (output valid, xa_0, xa_1, xa_2, xa_3, yb_0, yb_1, yb_2, yb_3,
                    input ready);
    modport sink (input valid, xa_0, xa_1, xa_2, xa_3, yb_0, yb_1, yb_2, yb_3,
                  output ready);
endinterface

interface sec_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] covariance;
    logic        coincident;

    modport source (output valid, covariance, coincident, input ready);
    modport sink (input valid, covariance, coincident, output ready);
endinterface

// ===== rtl/sec_front.sv =====
// Front part: accepts requests and forms the scaled squared distance.
// Depends on sec_pkg and sec_if.
module sec_front #(
    parameter int DIMS = 4
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    sec_in_if.sink                                      pairs,
    input  logic [sec_pkg::NLANE-1:0][sec_pkg::LEN_W-1:0] inv_len,
    input  logic                                        fifo_full,
    output logic                                        push,
    output sec_pkg::dist_t                              ent
);
    import sec_pkg::*;

    localparam int NUSED = (DIMS < NLANE) ? DIMS : NLANE;

    logic signed [COORD_W-1:0] xa [NLANE];
    logic signed [COORD_W-1:0] yb [NLANE];
    logic                      adv;
    logic                      acc;
    logic                      v1_reg, v2_reg, v3_reg, v4_reg;
    logic [COORD_W-1:0]        mag_reg [NLANE];
    logic [31:0]               z_reg [NLANE];
    logic [63:0]               sq_reg [NLANE];
    logic [65:0]               sum;
    logic [63:0]               m;
    dist_t                     ent_reg;

    assign xa[0] = pairs.xa_0;
    assign xa[1] = pairs.xa_1;
    assign xa[2] = pairs.xa_2;
    assign xa[3] = pairs.xa_3;
    assign yb[0] = pairs.yb_0;
    assign yb[1] = pairs.yb_1;
    assign yb[2] = pairs.yb_2;
    assign yb[3] = pairs.yb_3;

    // The whole front advances while the queue has room.
    assign adv         = !fifo_full;
    assign pairs.ready = adv;
    assign acc         = pairs.valid && adv;

    for (genvar d = 0; d < NLANE; d++) begin : g_lane
        logic signed [COORD_W:0] diff;
        logic        [COORD_W:0] mag;

        assign diff = {xa[d][COORD_W-1], xa[d]} - {yb[d][COORD_W-1], yb[d]};
        assign mag  = diff[COORD_W] ? (~diff + 1'b1) : diff;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                mag_reg[d] <= (d < NUSED) ? mag[COORD_W-1:0] : '0;
                z_reg[d]   <= mag_reg[d] * inv_len[d];
                sq_reg[d]  <= z_reg[d] * z_reg[d];
            end
        end
    end

    always_comb
    begin
        sum = '0;
        for (int d = 0; d < NLANE; d++)
        begin
            sum = sum + {2'b00, sq_reg[d]};
        end
        m = (sum[65:64] != 2'b00) ? '1 : sum[63:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= acc;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ent_reg.mq   <= m[MQ_W+15:16];
            ent_reg.coin <= (m == '0);
            ent_reg.near <= (m[63:39] == '0);
        end
    end

    assign push = v4_reg && adv;
    assign ent  = ent_reg;

endmodule

// ===== rtl/sec_fifo.sv =====
// Short queue between the distance front part and the exponent back part.
// Depends on sec_pkg.
module sec_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sec_pkg::dist_t      wdata,
    input  logic                pop,
    output sec_pkg::dist_t      rdata,
    output sec_pkg::fifo_stat_t stat
);
    import sec_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dist_t              mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push, do_pop;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign rdata      = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/sec_horner.sv =====
// One step of the exp(-x) series: p = 1 - floor(floor(x * p / 2^32) / K).
// Three register stages; depends on sec_pkg.
module sec_horner #(
    parameter int K = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  in_v,
    input  logic [31:0]           x_in,
    input  logic [32:0]           p_in,
    input  sec_pkg::side_t        side_in,
    output logic                  out_v,
    output logic [31:0]           x_out,
    output logic [32:0]           p_out,
    output sec_pkg::side_t        side_out
);
    import sec_pkg::*;

    localparam logic [RECIP_W-1:0] RC = recip(4'(K));
    localparam logic [35:0]        KV = 36'(K);

    logic               v1_reg, v2_reg, v3_reg;
    logic [31:0]        x1_reg, x2_reg, x3_reg;
    side_t              s1_reg, s2_reg, s3_reg;
    logic [31:0]        prod1_reg;
    logic [31:0]        val2_reg, qt2_reg;
    logic [32:0]        p3_reg;
    logic [64:0]        prod;
    logic [68:0]        qprod;
    logic [35:0]        rem;
    logic [31:0]        qt;

    assign prod  = x_in * p_in;
    assign qprod = prod1_reg * RC;
    assign rem   = {4'b0000, val2_reg} - ({4'b0000, qt2_reg} * KV);
    // The reciprocal estimate is low by at most one.
    assign qt    = (rem >= KV) ? qt2_reg + 1'b1 : qt2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_v;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x1_reg    <= x_in;
            s1_reg    <= side_in;
            prod1_reg <= prod[63:32];
            x2_reg    <= x1_reg;
            s2_reg    <= s1_reg;
            val2_reg  <= prod1_reg;
            qt2_reg   <= qprod[RECIP_SH+31:RECIP_SH];
            x3_reg    <= x2_reg;
            s3_reg    <= s2_reg;
            p3_reg    <= ONE_Q32 - {1'b0, qt};
        end
    end

    assign out_v    = v3_reg;
    assign x_out    = x3_reg;
    assign p_out    = p3_reg;
    assign side_out = s3_reg;

endmodule

// ===== rtl/sec_back.sv =====
// Back part: exponent split, exp series, amplitude scaling, nugget, result register.
// Depends on sec_pkg, sec_if and sec_horner.
module sec_back (
    input  logic                clk,
    input  logic                rst_n,
    input  sec_pkg::dist_t      ent,
    input  sec_pkg::fifo_stat_t stat,
    output logic                pop,
    input  logic [31:0]         amp_sqr,
    input  logic [31:0]         nugget_sqr,
    sec_out_if.source           results
);
    import sec_pkg::*;

    logic               adv;
    logic               b1_v_reg, b2_v_reg, k1_v_reg, out_v_reg;
    logic [54:0]        q_reg;
    dist_t              e1_reg;
    logic [31:0]        x_reg;
    side_t              s2_reg, k1_s_reg;
    logic [63:0]        xprod;
    logic [64:0]        amp_prod_reg;
    logic [64:0]        ap;
    logic               hv [ORDER+1];
    logic [31:0]        hx [ORDER+1];
    logic [32:0]        hp [ORDER+1];
    side_t              hs [ORDER+1];
    logic [64:0]        shifted;
    logic [31:0]        kern;
    logic [32:0]        total;
    logic [31:0]        cov_reg;
    logic               coin_reg;

    // Everything moves when the result register is free or being taken.
    assign adv = !out_v_reg || results.ready;
    assign pop = adv && !stat.empty;

    assign xprod = q_reg[47:16] * LN2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_v_reg  <= 1'b0;
            b2_v_reg  <= 1'b0;
            k1_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            b1_v_reg  <= pop;
            b2_v_reg  <= b1_v_reg;
            k1_v_reg  <= hv[ORDER];
            out_v_reg <= k1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_reg          <= ent.mq * HALF_LOG2E;
            e1_reg         <= ent;
            x_reg          <= xprod[63:32];
            s2_reg.n       <= q_reg[54:48];
            s2_reg.coin    <= e1_reg.coin;
            s2_reg.near    <= e1_reg.near;
            amp_prod_reg   <= ap;
            k1_s_reg       <= hs[ORDER];
            cov_reg        <= total[32] ? '1 : total[31:0];
            coin_reg       <= k1_s_reg.coin;
        end
    end

    assign hv[0] = b2_v_reg;
    assign hx[0] = x_reg;
    assign hp[0] = ONE_Q32;
    assign hs[0] = s2_reg;

    for (genvar i = 0; i < ORDER; i++) begin : g_step
        sec_horner #(.K(ORDER - i)) u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .in_v     (hv[i]),
            .x_in     (hx[i]),
            .p_in     (hp[i]),
            .side_in  (hs[i]),
            .out_v    (hv[i+1]),
            .x_out    (hx[i+1]),
            .p_out    (hp[i+1]),
            .side_out (hs[i+1])
        );
    end

    assign ap = amp_sqr * hp[ORDER];

    // Far items and exponents of 32 or more give no kernel contribution.
    assign shifted = amp_prod_reg >> k1_s_reg.n[4:0];
    assign kern    = (!k1_s_reg.near || (k1_s_reg.n >= NEXP_W'(32))) ? '0 : shifted[63:32];
    assign total   = {1'b0, kern} + (k1_s_reg.coin ? {1'b0, nugget_sqr} : 33'd0);

    assign results.valid      = out_v_reg;
    assign results.covariance = cov_reg;
    assign results.coincident = coin_reg;

endmodule

// ===== rtl/squared_exponential_covariance.sv =====
// Top level of the squared exponential (RBF, ARD) covariance block.
// Depends on sec_pkg, sec_if, sec_front, sec_fifo and sec_back.
//
// Usage: each request on the pairs channel carries two points of four signed
// Q8.8 coordinates. The block returns one result on the results channel: the
// kernel value amp_sqr * exp(-0.5 * m) in unsigned Q16.16, saturating, plus
// nugget_sqr and a raised coincident flag when the scaled distance m is zero.
// Requests are accepted with valid and ready both high; results likewise.
// Configuration is written through cfg_wr_en, cfg_index and cfg_data while
// the block is idle; indexes beyond the register list are ignored.
// A request passes in turn through the distance front part, the queue and the
// back part, which holds the twelve three-stage steps of the exp series.
// Throughput is one request per cycle while the receiver does not stall; every unit is fully pipelined.
// A stalled receiver holds the result register and freezes the back part;
// the queue then fills and ready drops on the pairs channel.
// Reset clears all valid state and loads amp_sqr with 1.0, nugget_sqr with
// zero and every inverse length scale with 1.0.
module squared_exponential_covariance #(
    parameter int DIMS       = 4,
    parameter int FIFO_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    sec_in_if.sink      pairs,
    sec_out_if.source   results,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import sec_pkg::*;

    logic [31:0]                  amp_sqr_reg;
    logic [31:0]                  nugget_sqr_reg;
    logic [NLANE-1:0][LEN_W-1:0]  inv_len_reg;
    logic                         fifo_push;
    logic                         fifo_pop;
    dist_t                        front_ent;
    dist_t                        fifo_head;
    fifo_stat_t                   fifo_stat;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amp_sqr_reg    <= 32'h0001_0000;
            nugget_sqr_reg <= '0;
            for (int i = 0; i < NLANE; i++)
            begin
                inv_len_reg[i] <= 16'h0100;
            end
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_AMP:  amp_sqr_reg    <= cfg_data;
                REG_NUG:  nugget_sqr_reg <= cfg_data;
                REG_LEN0: inv_len_reg[0] <= cfg_data[LEN_W-1:0];
                REG_LEN1: inv_len_reg[1] <= cfg_data[LEN_W-1:0];
                REG_LEN2: inv_len_reg[2] <= cfg_data[LEN_W-1:0];
                REG_LEN3: inv_len_reg[3] <= cfg_data[LEN_W-1:0];
                default:  ;
            endcase
        end
    end

    // The front part forms the distance and classifies it.
    sec_front #(.DIMS(DIMS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pairs     (pairs),
        .inv_len   (inv_len_reg),
        .fifo_full (fifo_stat.full),
        .push      (fifo_push),
        .ent       (front_ent)
    );

    // The queue lets the two parts stall independently.
    sec_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fifo_push),
        .wdata (front_ent),
        .pop   (fifo_pop),
        .rdata (fifo_head),
        .stat  (fifo_stat)
    );

    // The back part evaluates the exponential and drives the results.
    sec_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .ent        (fifo_head),
        .stat       (fifo_stat),
        .pop        (fifo_pop),
        .amp_sqr    (amp_sqr_reg),
        .nugget_sqr (nugget_sqr_reg),
        .results    (results)
    );

    // The front never pushes into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_push |-> !fifo_stat.full)
        else $error("request pushed into full queue");

    // The back never pops an empty queue.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_pop |-> !fifo_stat.empty)
        else $error("request popped from empty queue");

    // Pairs ready follows the queue's room only.
    a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
        pairs.ready == !fifo_stat.full)
        else $error("pairs ready disagrees with queue state");

endmodule
